@@ hdl/bdq_pkg.sv @@
// Shared types and constants for the bounded deque with cursor search.
`timescale 1ns / 1ps
`default_nettype none
package bdq_pkg;

  localparam int BDQ_DEPTH      = 16;
  localparam int BDQ_DATA_WIDTH = 32;

  localparam logic [2:0] OP_PREPEND = 3'd0;
  localparam logic [2:0] OP_APPEND  = 3'd1;
  localparam logic [2:0] OP_READ    = 3'd2;
  localparam logic [2:0] OP_RESET   = 3'd3;
  localparam logic [2:0] OP_SEARCH  = 3'd4;

  typedef enum logic {
    ST_IDLE,
    ST_WALK
  } state_t;

  // write controls broadcast to every cell
  typedef struct packed {
    logic prepend;
    logic append;
  } ctl_t;

  // flags of the probe token that walks the chain
  typedef struct packed {
    logic vld;
    logic srch;
    logic hit;
  } tok_t;

endpackage
`default_nettype wire

@@ hdl/bdq_cell.sv @@
// One deque cell: holds the entry at queue position IDX and passes the probe token on.
`timescale 1ns / 1ps
`default_nettype none
module bdq_cell import bdq_pkg::*; #(
  parameter int DATA_WIDTH = BDQ_DATA_WIDTH,
  parameter int IW         = 4,
  parameter int CW         = 5,
  parameter int IDX        = 0
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  ctl_t                  ctl,
  input  wire  [CW-1:0]         count,
  input  wire  [DATA_WIDTH-1:0] din,
  input  wire  [DATA_WIDTH-1:0] prev_entry,
  output logic [DATA_WIDTH-1:0] entry_q,
  input  tok_t                  tok_in,
  input  wire  [IW-1:0]         pos_in,
  input  wire  [DATA_WIDTH-1:0] word_in,
  output tok_t                  tok_out,
  output logic [IW-1:0]         pos_out,
  output logic [DATA_WIDTH-1:0] word_out
);

  logic [DATA_WIDTH-1:0] entry_r;
  tok_t                  tok_r, tok_nxt;
  logic [IW-1:0]         pos_r;
  logic [DATA_WIDTH-1:0] word_r, word_nxt;
  logic                  live;
  logic                  sel;

  assign live = CW'(IDX) < count;
  assign sel  = pos_in == IW'(IDX);

  // prepend shifts the whole row one cell toward the back
  always_ff @(posedge clk) begin
    if (ctl.prepend) begin
      entry_r <= prev_entry;
    end else if (ctl.append && (count == CW'(IDX))) begin
      entry_r <= din;
    end
  end

  always_comb begin
    tok_nxt  = tok_in;
    word_nxt = word_in;
    if (tok_in.vld) begin
      if (tok_in.srch) begin
        tok_nxt.hit = tok_in.hit | (live && (entry_r == word_in));
      end else if (sel) begin
        word_nxt = entry_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r  <= pos_in;
    word_r <= word_nxt;
  end

  assign entry_q  = entry_r;
  assign tok_out  = tok_r;
  assign pos_out  = pos_r;
  assign word_out = word_r;

endmodule
`default_nettype wire

@@ hdl/bounded_deque_with_cursor_search_core.sv @@
// Top level: bounded deque held in a shifting row of cells, with cursor read and search.
// Prepend, append, cursor reset, unused opcodes and reads past the end: result in the cycle
// after the input beat; a new beat is taken as soon as the result register frees up.
// Cursor read and search send a probe token down the DEPTH-cell row, one cell per cycle;
// the result is loaded as the token leaves the row, and no new beat is taken until then.
// Reset (rst_n, synchronous) empties the queue and puts the cursor past the end.
`timescale 1ns / 1ps
`default_nettype none
module bounded_deque_with_cursor_search_core import bdq_pkg::*; #(
  parameter int DEPTH      = BDQ_DEPTH,
  parameter int DATA_WIDTH = BDQ_DATA_WIDTH
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_ready,
  input  wire         [2:0]  in_opcode,
  input  wire  signed [31:0] in_value,
  output logic               out_valid,
  input  wire                out_ready,
  output logic signed [31:0] out_read_data,
  output logic               out_found,
  output logic        [4:0]  out_list_length,
  output logic               out_rejected
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int KW = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;
  localparam logic [31:0] WORD_MASK = 32'hFFFF_FFFF >> (32 - KW);

  state_t                state_r, state_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic [IW-1:0]         cur_pos_r, cur_pos_nxt;
  logic                  cur_vld_r, cur_vld_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [31:0]           rd_r, rd_nxt;
  logic                  found_r, found_nxt;
  logic [4:0]            len_r, len_nxt;
  logic                  rej_r, rej_nxt;

  logic                  accept;
  logic                  is_ins;
  logic                  full;
  logic                  launch;
  logic                  done;
  logic [31:0]           in_word;
  logic [DATA_WIDTH-1:0] din;
  ctl_t                  ctl;
  tok_t                  tok0;

  logic [DATA_WIDTH-1:0] ent  [DEPTH];
  tok_t                  tok  [DEPTH];
  logic [IW-1:0]         pos  [DEPTH];
  logic [DATA_WIDTH-1:0] word [DEPTH];

  assign accept  = in_valid && in_ready;
  assign in_word = in_value & WORD_MASK;
  assign din     = DATA_WIDTH'(in_word);
  assign full    = count_r == CW'(DEPTH);
  assign is_ins  = (in_opcode == OP_PREPEND) || (in_opcode == OP_APPEND);

  assign ctl.prepend = accept && (in_opcode == OP_PREPEND) && !full;
  assign ctl.append  = accept && (in_opcode == OP_APPEND) && !full;

  assign launch = accept &&
                  ((in_opcode == OP_SEARCH) || ((in_opcode == OP_READ) && cur_vld_r));
  assign tok0.vld  = launch;
  assign tok0.srch = in_opcode == OP_SEARCH;
  assign tok0.hit  = 1'b0;

  assign done = tok[DEPTH-1].vld;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      bdq_cell #(
        .DATA_WIDTH (DATA_WIDTH),
        .IW         (IW),
        .CW         (CW),
        .IDX        (i)
      ) u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .count      (count_r),
        .din        (din),
        .prev_entry (din),
        .entry_q    (ent[i]),
        .tok_in     (tok0),
        .pos_in     (cur_pos_r),
        .word_in    (din),
        .tok_out    (tok[i]),
        .pos_out    (pos[i]),
        .word_out   (word[i])
      );
    end else begin : g_body
      bdq_cell #(
        .DATA_WIDTH (DATA_WIDTH),
        .IW         (IW),
        .CW         (CW),
        .IDX        (i)
      ) u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .count      (count_r),
        .din        (din),
        .prev_entry (ent[i-1]),
        .entry_q    (ent[i]),
        .tok_in     (tok[i-1]),
        .pos_in     (pos[i-1]),
        .word_in    (word[i-1]),
        .tok_out    (tok[i]),
        .pos_out    (pos[i]),
        .word_out   (word[i])
      );
    end
  end

  // queue length and cursor, all settled at the input beat
  always_comb begin
    count_nxt   = count_r;
    cur_pos_nxt = cur_pos_r;
    cur_vld_nxt = cur_vld_r;
    if (accept) begin
      unique case (in_opcode)
        OP_PREPEND: begin
          if (!full) begin
            count_nxt   = count_r + CW'(1);
            cur_pos_nxt = '0;
            cur_vld_nxt = 1'b1;
          end
        end
        OP_APPEND: begin
          if (!full) begin
            count_nxt = count_r + CW'(1);
            if (count_r == '0) begin
              cur_pos_nxt = '0;
              cur_vld_nxt = 1'b1;
            end
          end
        end
        OP_READ: begin
          if (cur_vld_r) begin
            if (CW'(cur_pos_r) + CW'(1) == count_r) begin
              cur_vld_nxt = 1'b0;
            end else begin
              cur_pos_nxt = cur_pos_r + IW'(1);
            end
          end
        end
        OP_RESET: begin
          cur_pos_nxt = '0;
          cur_vld_nxt = count_r != '0;
        end
        default: begin
        end
      endcase
    end
  end

  // result register: loaded at the beat for short ops, at token exit for walks
  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    rd_nxt        = rd_r;
    found_nxt     = found_r;
    len_nxt       = len_r;
    rej_nxt       = rej_r;
    if (done) begin
      out_valid_nxt = 1'b1;
      rd_nxt        = tok[DEPTH-1].srch ? 32'd0 : 32'(word[DEPTH-1]);
      found_nxt     = tok[DEPTH-1].srch & tok[DEPTH-1].hit;
      len_nxt       = 5'(count_r);
      rej_nxt       = 1'b0;
    end else if (accept && !launch) begin
      out_valid_nxt = 1'b1;
      rd_nxt        = 32'd0;
      found_nxt     = 1'b0;
      len_nxt       = 5'(count_nxt);
      rej_nxt       = is_ins && full;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (launch) state_nxt = ST_WALK;
      ST_WALK: if (done) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    unique case (state_r)
      ST_IDLE: in_ready = !out_valid_r || out_ready;
      ST_WALK: in_ready = 1'b0;
      default: in_ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      cur_pos_r   <= '0;
      cur_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      cur_pos_r   <= cur_pos_nxt;
      cur_vld_r   <= cur_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_r    <= rd_nxt;
    found_r <= found_nxt;
    len_r   <= len_nxt;
    rej_r   <= rej_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_read_data   = rd_r;
  assign out_found       = found_r;
  assign out_list_length = len_r;
  assign out_rejected    = rej_r;

  a_done_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    done |-> state_r == ST_WALK)
    else $error("probe token left the row outside a walk");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("queue length above depth");

  a_cursor_in_queue: assert property (@(posedge clk) disable iff (!rst_n)
    cur_vld_r |-> (CW'(cur_pos_r) < count_r))
    else $error("valid cursor beyond back of queue");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_WALK |=> count_r == $past(count_r))
    else $error("queue length changed during a walk");

endmodule
`default_nettype wire

@@ bench/tb_bounded_deque_with_cursor_search_core.sv @@
// Testbench for the bounded deque core: directed table plus random traffic, checked per beat.
`timescale 1ns / 1ps
module tb_bounded_deque_with_cursor_search_core;
  import bdq_pkg::*;

  localparam logic [2:0] OP_UNUSED_LO = 3'd5;
  localparam logic [2:0] OP_UNUSED_HI = 3'd7;
  localparam int RAND_ITEMS  = 1800;
  localparam int HOLD_CYCLES = 200;
  localparam int STALL_LIMIT = 1000;
  localparam int DIR_ROWS    = 20;

  typedef struct packed {
    logic [31:0] rdata;
    logic        found;
    logic [4:0]  len;
    logic        rej;
  } deque_res_t;

  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] val;
    logic [5:0]  reps;
    logic        rnd;    // draw value at random
    logic        typed;  // use want instead of the predictor
    deque_res_t  want;
  } dir_row_t;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic        [2:0]  in_opcode;
  logic signed [31:0] in_value;
  logic               out_valid;
  logic               out_ready;
  logic signed [31:0] out_read_data;
  logic               out_found;
  logic        [4:0]  out_list_length;
  logic               out_rejected;

  // predicted deque contents and cursor
  logic [31:0] dq_word [BDQ_DEPTH];
  int          dq_front = 0;
  int          dq_len = 0;
  int          dq_cursor = 0;
  bit          dq_cursor_ok = 1'b0;

  deque_res_t  pending_res [$];
  int          err_count = 0;
  int          stall_cycles = 0;
  bit          hold_req = 1'b0;
  bit          no_idle = 1'b0;

  bounded_deque_with_cursor_search_core dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_opcode       (in_opcode),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_read_data   (out_read_data),
    .out_found       (out_found),
    .out_list_length (out_list_length),
    .out_rejected    (out_rejected)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic deque_res_t deque_step(logic [2:0] op, logic [31:0] val);
    deque_res_t r;
    int slot;
    r = '0;
    case (op)
      OP_PREPEND, OP_APPEND: begin
        if (dq_len >= BDQ_DEPTH) begin
          r.rej = 1'b1;
        end else if (op == OP_PREPEND) begin
          if (dq_len != 0) dq_front = (dq_front + BDQ_DEPTH - 1) % BDQ_DEPTH;
          dq_word[dq_front] = val;
          dq_len++;
          dq_cursor = dq_front;
          dq_cursor_ok = 1'b1;
        end else begin
          slot = (dq_front + dq_len) % BDQ_DEPTH;
          dq_word[slot] = val;
          // cursor follows an append only into an empty queue
          if (dq_len == 0) begin
            dq_cursor = slot;
            dq_cursor_ok = 1'b1;
          end
          dq_len++;
        end
      end
      OP_READ: begin
        if (dq_cursor_ok && dq_len != 0) begin
          r.rdata = dq_word[dq_cursor];
          if (dq_cursor == (dq_front + dq_len - 1) % BDQ_DEPTH) dq_cursor_ok = 1'b0;
          else dq_cursor = (dq_cursor + 1) % BDQ_DEPTH;
        end else begin
          dq_cursor_ok = 1'b0;
        end
      end
      OP_RESET: begin
        dq_cursor = dq_front;
        dq_cursor_ok = (dq_len != 0);
      end
      OP_SEARCH: begin
        for (int i = 0; i < dq_len; i++) begin
          if (dq_word[(dq_front + i) % BDQ_DEPTH] == val) r.found = 1'b1;
        end
      end
      default: ;
    endcase
    r.len = dq_len[4:0];
    return r;
  endfunction

  task automatic note_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
    err_count++;
  endtask

  task automatic drive_item(logic [2:0] op, logic [31:0] val, deque_res_t res);
    while (!no_idle && $urandom_range(99) < 26) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_opcode <= op;
    in_value  <= val;
    do @(posedge clk); while (!in_ready);
    pending_res.push_back(res);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_res.size() != 0) @(posedge clk);
  endtask

  // result beat check and stall watchdog
  always @(posedge clk) begin : chk
    deque_res_t w;
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (out_valid && out_ready) begin
        if (pending_res.size() == 0) begin
          note_mismatch("unexpected beat", out_read_data, 32'd0);
        end else begin
          w = pending_res.pop_front();
          if (out_read_data !== w.rdata) note_mismatch("read_data", out_read_data, w.rdata);
          if (out_found !== w.found)
            note_mismatch("found", 32'(out_found), 32'(w.found));
          if (out_list_length !== w.len)
            note_mismatch("list_length", 32'(out_list_length), 32'(w.len));
          if (out_rejected !== w.rej)
            note_mismatch("rejected", 32'(out_rejected), 32'(w.rej));
        end
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  // receiver: random backpressure, one long hold-off on request
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_ready <= no_idle || ($urandom_range(99) >= 26);
      end
    end
  end

  initial begin : stim
    dir_row_t   tab [DIR_ROWS];
    deque_res_t res;
    logic [2:0] op;
    logic [31:0] val;
    int roll;

    tab = '{
      '{OP_READ,      32'h0000_0000, 6'd1, 1'b0, 1'b1, '{32'h0, 1'b0, 5'd0, 1'b0}},
      '{OP_RESET,     32'h0000_0000, 6'd1, 1'b0, 1'b1, '{32'h0, 1'b0, 5'd0, 1'b0}},
      '{OP_SEARCH,    32'h0000_0000, 6'd1, 1'b0, 1'b1, '{32'h0, 1'b0, 5'd0, 1'b0}},
      '{OP_UNUSED_HI, 32'hFFFF_FFFF, 6'd1, 1'b0, 1'b1, '{32'h0, 1'b0, 5'd0, 1'b0}},
      '{OP_APPEND,    32'h8000_0000, 6'd1, 1'b0, 1'b1, '{32'h0, 1'b0, 5'd1, 1'b0}},
      '{OP_READ,      32'h0000_0000, 6'd1, 1'b0, 1'b1, '{32'h8000_0000, 1'b0, 5'd1, 1'b0}},
      '{OP_READ,      32'h0000_0000, 6'd1, 1'b0, 1'b1, '{32'h0, 1'b0, 5'd1, 1'b0}},
      // append into a non-empty queue leaves the cursor past the end
      '{OP_APPEND,    32'h7FFF_FFFF, 6'd1, 1'b0, 1'b1, '{32'h0, 1'b0, 5'd2, 1'b0}},
      '{OP_READ,      32'h0000_0000, 6'd1, 1'b0, 1'b1, '{32'h0, 1'b0, 5'd2, 1'b0}},
      '{OP_PREPEND,   32'h0000_0000, 6'd1, 1'b0, 1'b1, '{32'h0, 1'b0, 5'd3, 1'b0}},
      '{OP_READ,      32'h0000_0000, 6'd1, 1'b0, 1'b1, '{32'h0, 1'b0, 5'd3, 1'b0}},
      '{OP_READ,      32'h0000_0000, 6'd1, 1'b0, 1'b1, '{32'h8000_0000, 1'b0, 5'd3, 1'b0}},
      '{OP_READ,      32'h0000_0000, 6'd1, 1'b0, 1'b1, '{32'h7FFF_FFFF, 1'b0, 5'd3, 1'b0}},
      '{OP_READ,      32'h0000_0000, 6'd1, 1'b0, 1'b1, '{32'h0, 1'b0, 5'd3, 1'b0}},
      '{OP_SEARCH,    32'h7FFF_FFFF, 6'd1, 1'b0, 1'b1, '{32'h0, 1'b1, 5'd3, 1'b0}},
      '{OP_SEARCH,    32'h8000_0001, 6'd1, 1'b0, 1'b1, '{32'h0, 1'b0, 5'd3, 1'b0}},
      '{OP_PREPEND,   32'h0000_0000, 6'd3, 1'b1, 1'b0, '0},
      '{OP_RESET,     32'h0000_0000, 6'd1, 1'b0, 1'b1, '{32'h0, 1'b0, 5'd6, 1'b0}},
      '{OP_READ,      32'h0000_0000, 6'd2, 1'b1, 1'b0, '0},
      '{OP_UNUSED_LO, 32'h0000_0000, 6'd1, 1'b1, 1'b0, '0}
    };

    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_opcode = OP_PREPEND;
    in_value  = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (tab[i]) begin
      for (int k = 0; k < tab[i].reps; k++) begin
        val = tab[i].rnd ? 32'($urandom) : tab[i].val;
        res = deque_step(tab[i].op, val);
        if (tab[i].typed) res = tab[i].want;
        drive_item(tab[i].op, val, res);
      end
    end
    wait_drained();

    // inserts are rare so the queue fills slowly and partial lengths get exercised
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n == 400) hold_req = 1'b1;
      if (n == 1000) wait_drained();
      no_idle = (n >= 1200 && n < 1500);
      roll = $urandom_range(99);
      val = $urandom;
      if (roll < 2) begin
        op = (roll == 0) ? OP_PREPEND : OP_APPEND;
        case ($urandom_range(9))
          0: val = 32'h7FFF_FFFF;
          1: val = 32'h8000_0000;
          2: val = 32'h0000_0000;
          3: val = 32'hFFFF_FFFF;
          default: ;
        endcase
      end else if (roll < 40) begin
        op = OP_READ;
      end else if (roll < 50) begin
        op = OP_RESET;
      end else if (roll < 95) begin
        op = OP_SEARCH;
        if (dq_len != 0 && $urandom_range(1) == 1)
          val = dq_word[(dq_front + $urandom_range(dq_len - 1)) % BDQ_DEPTH];
      end else begin
        op = 3'($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO));
      end
      res = deque_step(op, val);
      drive_item(op, val, res);
    end

    wait_drained();
    repeat (BDQ_DEPTH + 4) @(posedge clk);
    if (err_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
